FILE: design/iirt_pkg.sv
// ----------------------------------------------------------------------------
// iirt_pkg
// Shared types and constants for the transposed second-order IIR filter.
// ----------------------------------------------------------------------------
package iirt_pkg;

    localparam int SAMPLE_BITS     = 16;
    localparam int COEF_BITS       = 32;
    localparam int STATE_BITS      = 48;
    localparam int COEF_FRAC_BITS  = 28;
    localparam int CFG_INDEX_BITS  = 3;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          first;
    } in_word_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] filtered;
        logic                          saturated;
    } out_word_t;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_B0   = 3'd0,
        REG_B1   = 3'd1,
        REG_B2   = 3'd2,
        REG_A1   = 3'd3,
        REG_A2   = 3'd4,
        REG_GAIN = 3'd5
    } cfg_reg_t;

    typedef enum logic [2:0] {
        SEL_B0,
        SEL_B1,
        SEL_B2,
        SEL_A1,
        SEL_A2,
        SEL_GAIN
    } coef_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_PROD_D2,
        ACC_SUB,
        ACC_PROD
    } acc_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_G_MUL,
        ST_PRESET,
        ST_B0_MUL,
        ST_Y_CALC,
        ST_A1_MUL,
        ST_B2_MUL,
        ST_A2_MUL,
        ST_D2_UPD,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic      in_load;
        logic      mul_en;
        coef_sel_t coef_sel;
        logic      use_y;
        acc_op_t   acc_op;
        logic      preset;
        logic      d1_from_acc;
        logic      d2_from_diff;
        logic      y_calc;
        logic      out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic out_full;
    } dp_status_t;

endpackage

FILE: design/iirt_ctrl.sv
// ----------------------------------------------------------------------------
// iirt_ctrl
// Sequencer: steps one sample through the shared multiplier and accumulator.
// ----------------------------------------------------------------------------
module iirt_ctrl import iirt_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       in_first,
    output logic       s_ready,
    input  logic       m_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next       = state_reg;
        s_ready          = 1'b0;
        cmd.in_load      = 1'b0;
        cmd.mul_en       = 1'b0;
        cmd.coef_sel     = SEL_B0;
        cmd.use_y        = 1'b0;
        cmd.acc_op       = ACC_HOLD;
        cmd.preset       = 1'b0;
        cmd.d1_from_acc  = 1'b0;
        cmd.d2_from_diff = 1'b0;
        cmd.y_calc       = 1'b0;
        cmd.out_load     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.in_load = 1'b1;
                    state_next  = in_first ? ST_G_MUL : ST_B0_MUL;
                end
            end
            ST_G_MUL: begin
                cmd.mul_en   = 1'b1;
                cmd.coef_sel = SEL_GAIN;
                state_next   = ST_PRESET;
            end
            ST_PRESET: begin
                cmd.preset = 1'b1;
                state_next = ST_B0_MUL;
            end
            ST_B0_MUL: begin
                cmd.mul_en   = 1'b1;
                cmd.coef_sel = SEL_B0;
                state_next   = ST_Y_CALC;
            end
            ST_Y_CALC: begin
                // round and clip b0*x + d1 while b1*x is formed
                cmd.y_calc   = 1'b1;
                cmd.mul_en   = 1'b1;
                cmd.coef_sel = SEL_B1;
                state_next   = ST_A1_MUL;
            end
            ST_A1_MUL: begin
                cmd.acc_op   = ACC_PROD_D2;
                cmd.mul_en   = 1'b1;
                cmd.coef_sel = SEL_A1;
                cmd.use_y    = 1'b1;
                state_next   = ST_B2_MUL;
            end
            ST_B2_MUL: begin
                cmd.acc_op   = ACC_SUB;
                cmd.mul_en   = 1'b1;
                cmd.coef_sel = SEL_B2;
                state_next   = ST_A2_MUL;
            end
            ST_A2_MUL: begin
                cmd.d1_from_acc = 1'b1;
                cmd.acc_op      = ACC_PROD;
                cmd.mul_en      = 1'b1;
                cmd.coef_sel    = SEL_A2;
                cmd.use_y       = 1'b1;
                state_next      = ST_D2_UPD;
            end
            ST_D2_UPD: begin
                cmd.d2_from_diff = 1'b1;
                state_next       = ST_OUT;
            end
            ST_OUT: begin
                // hold until the output register is free
                if (!status.out_full || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: design/iirt_dp.sv
// ----------------------------------------------------------------------------
// iirt_dp
// Datapath: coefficient registers, shared multiplier, accumulator, delay
// states, rounding and clipping, and the output register.
// ----------------------------------------------------------------------------
module iirt_dp import iirt_pkg::*; #(
    parameter int COEF_FRAC_BITS = iirt_pkg::COEF_FRAC_BITS
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_valid,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [COEF_BITS-1:0]      cfg_data,
    input  in_word_t                  s_data,
    output out_word_t                 m_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    input  dp_cmd_t                   cmd,
    output dp_status_t                status
);

    localparam int PROD_W = COEF_BITS + SAMPLE_BITS;
    localparam int ACC_W  = ((PROD_W > STATE_BITS) ? PROD_W : STATE_BITS) + 2;
    localparam int RND_W  = ACC_W + 1;

    localparam logic signed [COEF_BITS-1:0] ONE =
        COEF_BITS'(1) << COEF_FRAC_BITS;
    localparam logic signed [RND_W-1:0] HALF =
        RND_W'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [RND_W-1:0] Y_MAX =
        {{(RND_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [RND_W-1:0] Y_MIN = ~Y_MAX;
    localparam logic signed [ACC_W-1:0] S_MAX =
        {{(ACC_W-STATE_BITS+1){1'b0}}, {(STATE_BITS-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] S_MIN = ~S_MAX;

    function automatic logic signed [STATE_BITS-1:0] clamp_state(
        input logic signed [ACC_W-1:0] v
    );
        logic signed [STATE_BITS-1:0] r;
        if (v > S_MAX) begin
            r = S_MAX[STATE_BITS-1:0];
        end else if (v < S_MIN) begin
            r = S_MIN[STATE_BITS-1:0];
        end else begin
            r = v[STATE_BITS-1:0];
        end
        return r;
    endfunction

    logic signed [COEF_BITS-1:0]   b0_reg, b1_reg, b2_reg, a1_reg, a2_reg, gain_reg;
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic signed [SAMPLE_BITS-1:0] y_reg;
    logic                          sat_reg;
    logic signed [PROD_W-1:0]      prod_reg;
    logic signed [PROD_W-1:0]      prod_next;
    logic signed [ACC_W-1:0]       acc_reg;
    logic signed [ACC_W-1:0]       acc_next;
    logic signed [STATE_BITS-1:0]  d1_reg, d2_reg;
    logic                          m_valid_reg;
    logic                          m_valid_next;
    out_word_t                     out_reg;

    logic signed [COEF_BITS-1:0]   coef_mux;
    logic signed [SAMPLE_BITS-1:0] opnd_mux;
    logic signed [ACC_W-1:0]       prod_ext;
    logic signed [ACC_W-1:0]       diff;
    logic signed [RND_W-1:0]       rnd_sum;
    logic signed [RND_W-1:0]       rnd;
    logic signed [SAMPLE_BITS-1:0] y_next;
    logic                          sat_next;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b0_reg   <= ONE;
            b1_reg   <= '0;
            b2_reg   <= '0;
            a1_reg   <= '0;
            a2_reg   <= '0;
            gain_reg <= ONE;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_B0:   b0_reg   <= cfg_data;
                REG_B1:   b1_reg   <= cfg_data;
                REG_B2:   b2_reg   <= cfg_data;
                REG_A1:   a1_reg   <= cfg_data;
                REG_A2:   a2_reg   <= cfg_data;
                REG_GAIN: gain_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cmd.coef_sel)
            SEL_B0:   coef_mux = b0_reg;
            SEL_B1:   coef_mux = b1_reg;
            SEL_B2:   coef_mux = b2_reg;
            SEL_A1:   coef_mux = a1_reg;
            SEL_A2:   coef_mux = a2_reg;
            SEL_GAIN: coef_mux = gain_reg;
            default:  coef_mux = b0_reg;
        endcase
    end

    assign opnd_mux  = cmd.use_y ? y_reg : x_reg;
    assign prod_next = coef_mux * opnd_mux;
    assign prod_ext  = ACC_W'(prod_reg);
    assign diff      = acc_reg - prod_ext;

    // round to nearest, ties upward, then clip to the sample range
    assign rnd_sum = RND_W'(prod_reg) + RND_W'(d1_reg) + HALF;
    assign rnd     = rnd_sum >>> COEF_FRAC_BITS;

    always_comb begin
        if (rnd > Y_MAX) begin
            y_next   = Y_MAX[SAMPLE_BITS-1:0];
            sat_next = 1'b1;
        end else if (rnd < Y_MIN) begin
            y_next   = Y_MIN[SAMPLE_BITS-1:0];
            sat_next = 1'b1;
        end else begin
            y_next   = rnd[SAMPLE_BITS-1:0];
            sat_next = 1'b0;
        end
    end

    always_comb begin
        case (cmd.acc_op)
            ACC_HOLD:    acc_next = acc_reg;
            ACC_PROD_D2: acc_next = prod_ext + ACC_W'(d2_reg);
            ACC_SUB:     acc_next = diff;
            ACC_PROD:    acc_next = prod_ext;
            default:     acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        if (cmd.in_load) begin
            x_reg <= s_data.sample;
        end
        if (cmd.mul_en) begin
            prod_reg <= prod_next;
        end
        if (cmd.y_calc) begin
            y_reg   <= y_next;
            sat_reg <= sat_next;
        end
        if (cmd.out_load) begin
            out_reg.filtered  <= y_reg;
            out_reg.saturated <= sat_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d1_reg <= '0;
            d2_reg <= '0;
        end else begin
            if (cmd.preset) begin
                d1_reg <= clamp_state(prod_ext);
                d2_reg <= clamp_state(prod_ext);
            end
            if (cmd.d1_from_acc) begin
                d1_reg <= clamp_state(acc_reg);
            end
            if (cmd.d2_from_diff) begin
                d2_reg <= clamp_state(diff);
            end
        end
    end

    assign m_valid_next = cmd.out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_data          = out_reg;
    assign status.out_full = m_valid_reg;

endmodule

FILE: design/iir_transposed_second_order.sv
// ----------------------------------------------------------------------------
// iir_transposed_second_order
// Second-order IIR filter, transposed direct form II, fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry one input word: a signed sample and a first
//   flag. A word flagged first presets both delay states to start_gain*x.
//   m_valid/m_ready/m_data carry one result word per input word: the
//   filtered sample, clipped to the sample range, and a saturated flag.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write coefficients b0, b1, b2, a1,
//   a2 and start_gain (indexes 0 to 5, others ignored); write only when idle.
// Timing:
//   one multiplier is shared by all products, at most one product a cycle, so a
//   word passes the steps b0, y, a1, b2, a2, d2 and out in order (gain and
//   preset first when the first flag is set), and the next word is taken
//   only once the sequencer has returned to idle after the out step.
// Reset:
//   aresetn restores the default coefficients (b0 and start_gain 1.0, the
//   rest 0), clears both delay states and empties the output register.
// Stalls:
//   a result waits in the output register; the next word is accepted and
//   worked on meanwhile, and is held at its last step until the register
//   frees up.
// ----------------------------------------------------------------------------
module iir_transposed_second_order import iirt_pkg::*; #(
    parameter int COEF_FRAC_BITS = iirt_pkg::COEF_FRAC_BITS
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  in_word_t                  s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output out_word_t                 m_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [COEF_BITS-1:0]      cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    iirt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .in_first (s_data.first),
        .s_ready  (s_ready),
        .m_ready  (m_ready),
        .status   (status),
        .cmd      (cmd)
    );

    iirt_dp #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .m_data    (m_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
